// ===== hdl/sem_pkg.sv =====
// Shared types, constants and helper functions of the Sobel edge magnitude block.
package sem_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;
  localparam int PIXEL_W = 8;
  localparam int CFG_W = 12;
  localparam int MAG_W = 11;
  localparam int MIN_WIDTH = 3;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 12'd2048;

  // row count saturates once the window spans three rows
  localparam logic [1:0] ROW_FULL = 2'd2;

  // position flags of one pixel, from the counter unit to the datapath
  typedef struct packed {
    logic [1:0] row;
    logic       interior;
    logic       last;
  } pix_pos_t;

  // line width clamped to the supported range
  function automatic int eff_width(input logic [CFG_W-1:0] v, input int max_w);
    int w;
    w = int'(v);
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > max_w) w = max_w;
    return w;
  endfunction

  // saturating row increment
  function automatic logic [1:0] row_inc(input logic [1:0] r);
    return (r == ROW_FULL) ? ROW_FULL : r + 2'd1;
  endfunction

endpackage

// ===== hdl/sem_line_store.sv =====
// One line store: single write port, single registered read port.
module sem_line_store
  import sem_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEFAULT,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [PIXEL_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sem_pixel_ctrl.sv =====
// Line width register and column / row counters of the pixel stream.
module sem_pixel_ctrl
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  parameter int CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             adv,
  input  logic             frame_start,
  output logic [CW-1:0]    col,
  output pix_pos_t         pos
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [WW-1:0] width;
  logic [CW-1:0] column_count, column_count_next;
  logic [1:0]    row_count, row_count_next;
  logic [CW-1:0] cc0;
  logic [1:0]    rc0;
  logic          wrap;

  // effective width, clamped at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WW'(eff_width(LINE_WIDTH_RESET, MAX_WIDTH));
    end else if (cfg_we) begin
      width <= WW'(eff_width(cfg_data, MAX_WIDTH));
    end
  end

  // position of the arriving pixel and the counts after it
  always_comb begin
    cc0 = frame_start ? '0 : column_count;
    rc0 = frame_start ? '0 : row_count;
    // a shrunk width starts a new row
    wrap = (WW'(cc0) >= width);
    col = wrap ? '0 : cc0;
    pos.row = wrap ? row_inc(rc0) : rc0;
    pos.interior = (pos.row == ROW_FULL) && (col >= CW'(2));
    pos.last = (WW'(col) == width - WW'(1));
    column_count_next = pos.last ? '0 : col + CW'(1);
    row_count_next = pos.last ? row_inc(pos.row) : pos.row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
    end else if (adv) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

// ===== hdl/sem_kernel.sv =====
// 3x3 window registers and the Sobel X/Y gradient L1 magnitude.
module sem_kernel
  import sem_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic [PIXEL_W-1:0] top,
  input  logic [PIXEL_W-1:0] mid,
  input  logic [PIXEL_W-1:0] bot,
  output logic [MAG_W-1:0]   magnitude
);

  // entries 0..2: column c-2, 3..5: column c-1, top to bottom
  logic [PIXEL_W-1:0] win [6];
  logic signed [11:0] tl, ml, bl, tm, bm, tr, mr, br;
  logic signed [11:0] gx, gy;
  logic [11:0] ax, ay;

  // window shift, one column per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

  // gradients and magnitude
  always_comb begin
    tl = $signed({4'b0, win[0]});
    ml = $signed({4'b0, win[1]});
    bl = $signed({4'b0, win[2]});
    tm = $signed({4'b0, win[3]});
    bm = $signed({4'b0, win[5]});
    tr = $signed({4'b0, top});
    mr = $signed({4'b0, mid});
    br = $signed({4'b0, bot});
    gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
    gy = (bl + (bm <<< 1) + br) - (tl + (tm <<< 1) + tr);
    ax = gx[11] ? 12'(-gx) : 12'(gx);
    ay = gy[11] ? 12'(-gy) : 12'(gy);
    magnitude = ax[MAG_W-1:0] + ay[MAG_W-1:0];
  end

endmodule

// ===== hdl/sobel_edge_magnitude.sv =====
// Streaming 3x3 Sobel edge detector giving |gx|+|gy| for interior pixels.
// The pixel below-right of the window centre is registered in stage 1, and its
// result then in the output register; stage 1 holds while the output is blocked.
// Throughput: one pixel per cycle while the output is not blocked, set by the one read
// and one write per cycle of each line store; border pixels give no result.
// Reset: clears counters, window and valid flags, width returns to 2048 (clamped to
// MAX_WIDTH); line stores are not cleared.
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,   // line_width
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,    // [7:0] pixel
  input  logic             s_tuser,    // frame_start
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,    // [10:0] magnitude, rest zero
  output logic             m_tlast     // row_end
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic               accept;
  logic [CW-1:0]      in_col;
  pix_pos_t           in_pos;
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_px;
  logic [CW-1:0]      s1_col;
  pix_pos_t           s1_pos;
  logic               s1_go;
  logic               s1_shift;
  logic [PIXEL_W-1:0] rd_up, rd_mid;
  logic [PIXEL_W-1:0] top, mid;
  logic [MAG_W-1:0]   mag;

  // handshake: stage 1 moves on unless it holds a result blocked at the output
  assign s1_go = !s1_pos.interior || !m_tvalid || m_tready;
  assign s1_shift = s1_valid && s1_go;
  assign s_tready = !s1_valid || s1_go;
  assign accept = s_tvalid && s_tready;

  sem_pixel_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .adv(accept),
    .frame_start(s_tuser),
    .col(in_col),
    .pos(in_pos)
  );

  // line stores: read on transfer, write back when stage 1 moves on
  sem_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW(CW)
  ) u_upper (
    .clk(clk),
    .we(s1_shift),
    .waddr(s1_col),
    .wdata(mid),
    .re(accept),
    .raddr(in_col),
    .rdata(rd_up)
  );

  sem_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW(CW)
  ) u_middle (
    .clk(clk),
    .we(s1_shift),
    .waddr(s1_col),
    .wdata(s1_px),
    .re(accept),
    .raddr(in_col),
    .rdata(rd_mid)
  );

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px <= s_tdata;
      s1_col <= in_col;
      s1_pos <= in_pos;
    end
  end

  // row zero sees no stored rows
  assign top = (s1_pos.row != 2'd0) ? rd_up : '0;
  assign mid = (s1_pos.row != 2'd0) ? rd_mid : '0;

  sem_kernel u_kernel (
    .clk(clk),
    .rst(rst),
    .shift(s1_shift),
    .top(top),
    .mid(mid),
    .bot(s1_px),
    .magnitude(mag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_shift && s1_pos.interior) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_shift && s1_pos.interior) begin
      m_tdata <= {5'b0, mag};
      m_tlast <= s1_pos.last;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid && !s1_valid)
    else $error("pipeline valid flags not cleared by reset");
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    s1_shift && s1_pos.interior |=> m_tvalid)
    else $error("interior result lost between stage 1 and output");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_col) && $stable(s1_px))
    else $error("stalled stage 1 item changed");
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:11] == 5'd0) && (m_tdata[10:0] <= 11'd2040))
    else $error("magnitude out of range");
`endif

endmodule
